/* rtl/core/qfs_pkg.sv */
// ----------------------------------------------------------------------------
// qfs_pkg
// Types and character constants shared by the quoted field splitter modules.
// ----------------------------------------------------------------------------
package qfs_pkg;

  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_BLANK     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;

  localparam logic [7:0] DELIM_RESET  = 8'd44;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [0:0] REG_DELIMITER = 1'b0;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_PLAIN  = 3'd1,
    PH_QUOTED = 3'd2,
    PH_ESCAPE = 3'd3,
    PH_CLOSED = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_DISCARD = 2'd1,
    KIND_END     = 2'd2
  } kind_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } result_t;

endpackage

/* rtl/core/quoted_field_splitter_core.sv */
// ----------------------------------------------------------------------------
// quoted_field_splitter_core
// Splits a byte stream into quoted or unquoted fields, one byte per beat.
// ----------------------------------------------------------------------------
// Each input beat carries one text byte and yields zero or one output beat: a
// content byte (tuser 0), a discard of the field's bytes so far (tuser 1) or a
// field end (tuser 2, tlast set when the zero byte ended the text). A byte is
// taken into an input register, parsed by one step of the phase machine and
// its result lands in an output register. A new byte is accepted every cycle
// while the output side keeps up; a byte that produces no result never waits
// for the output register. The delimiter is written over APB at address 0
// (reset 44, a comma; zero makes bytes 1 to 0x20 separate) and should only
// change while the stream is idle.
module quoted_field_splitter_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] in_byte
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // [7:0] out_byte
  output logic [1:0]                      out_tuser,  // [1:0] out_kind
  output logic                            out_tlast,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [qfs_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [qfs_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [qfs_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);

  logic [7:0]       delimiter;
  logic             in_valid_r;
  logic             in_valid_nxt;
  logic [7:0]       in_byte_r;
  logic [7:0]       in_byte_nxt;
  qfs_pkg::phase_t  phase_r;
  qfs_pkg::phase_t  phase_nxt;
  qfs_pkg::phase_t  step_phase;
  qfs_pkg::result_t step_res;
  qfs_pkg::result_t out_r;
  qfs_pkg::result_t out_nxt;
  logic             out_free;
  logic             step_go;
  logic             in_fire;

  qfs_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .delimiter  (delimiter)
  );

  qfs_parse_step u_step (
    .phase    (phase_r),
    .in_byte  (in_byte_r),
    .delimiter(delimiter),
    .phase_nxt(step_phase),
    .result   (step_res)
  );

  assign out_free  = !out_r.valid || out_tready;
  // The held byte retires when its result, if any, has room downstream.
  assign step_go   = in_valid_r && (out_free || !step_res.valid);
  assign in_tready = !in_valid_r || step_go;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    in_byte_nxt  = in_byte_r;
    phase_nxt    = phase_r;
    out_nxt      = out_r;
    if (out_r.valid && out_tready) begin
      out_nxt.valid = 1'b0;
    end
    if (step_go) begin
      phase_nxt    = step_phase;
      in_valid_nxt = 1'b0;
      if (step_res.valid) begin
        out_nxt = step_res;
      end
    end
    if (in_fire) begin
      in_valid_nxt = 1'b1;
      in_byte_nxt  = in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      phase_r    <= qfs_pkg::PH_START;
      out_r      <= '0;
    end else begin
      in_valid_r <= in_valid_nxt;
      phase_r    <= phase_nxt;
      out_r      <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_byte_r <= in_byte_nxt;
  end

  assign out_tvalid = out_r.valid;
  assign out_tdata  = out_r.data;
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;

endmodule

/* rtl/core/qfs_cfg_regs.sv */
// ----------------------------------------------------------------------------
// qfs_cfg_regs
// APB register file holding the delimiter byte.
// ----------------------------------------------------------------------------
module qfs_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [qfs_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [qfs_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [qfs_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready,
  output logic [7:0]                      delimiter
);

  logic [7:0] delim_r;
  logic [7:0] delim_nxt;
  logic       sel_delim;

  assign cfg_pready = 1'b1;
  assign sel_delim  = (cfg_paddr[qfs_pkg::CFG_ADDR_W-1] == qfs_pkg::REG_DELIMITER);

  always_comb begin
    delim_nxt = delim_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && sel_delim) begin
      delim_nxt = cfg_pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= qfs_pkg::DELIM_RESET;
    end else begin
      delim_r <= delim_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (sel_delim) begin
      cfg_prdata = {{(qfs_pkg::CFG_DATA_W-8){1'b0}}, delim_r};
    end
  end

  assign delimiter = delim_r;

endmodule

/* rtl/core/qfs_parse_step.sv */
// ----------------------------------------------------------------------------
// qfs_parse_step
// Combinational parser step: next phase and the result caused by one byte.
// ----------------------------------------------------------------------------
module qfs_parse_step (
  input  qfs_pkg::phase_t  phase,
  input  logic [7:0]       in_byte,
  input  logic [7:0]       delimiter,
  output qfs_pkg::phase_t  phase_nxt,
  output qfs_pkg::result_t result
);

  logic is_nul;
  logic is_quote;
  logic is_bslash;
  logic is_blank;
  logic is_sep;

  assign is_nul    = (in_byte == qfs_pkg::CH_NUL);
  assign is_quote  = (in_byte == qfs_pkg::CH_QUOTE);
  assign is_bslash = (in_byte == qfs_pkg::CH_BACKSLASH);
  assign is_blank  = (in_byte <= qfs_pkg::CH_BLANK);
  assign is_sep    = is_nul || (in_byte == delimiter) ||
                     ((delimiter == qfs_pkg::CH_NUL) && is_blank);

  // Next phase.
  always_comb begin
    phase_nxt = phase;
    case (phase)
      qfs_pkg::PH_QUOTED: begin
        if (is_nul) begin
          phase_nxt = qfs_pkg::PH_START;
        end else if (is_quote) begin
          phase_nxt = (delimiter == qfs_pkg::CH_QUOTE) ? qfs_pkg::PH_START
                                                       : qfs_pkg::PH_CLOSED;
        end else if (is_bslash) begin
          phase_nxt = qfs_pkg::PH_ESCAPE;
        end
      end
      qfs_pkg::PH_ESCAPE: begin
        phase_nxt = is_nul ? qfs_pkg::PH_START : qfs_pkg::PH_QUOTED;
      end
      qfs_pkg::PH_CLOSED: begin
        if (is_sep) begin
          phase_nxt = qfs_pkg::PH_START;
        end
      end
      qfs_pkg::PH_PLAIN: begin
        if (is_quote) begin
          phase_nxt = qfs_pkg::PH_QUOTED;
        end else if (is_sep) begin
          phase_nxt = qfs_pkg::PH_START;
        end
      end
      default: begin
        // Field start; unused codes behave the same way.
        if (is_quote) begin
          phase_nxt = qfs_pkg::PH_QUOTED;
        end else if (is_sep || is_blank) begin
          phase_nxt = qfs_pkg::PH_START;
        end else begin
          phase_nxt = qfs_pkg::PH_PLAIN;
        end
      end
    endcase
  end

  // Result of this byte.
  always_comb begin
    result       = '0;
    result.kind  = qfs_pkg::KIND_BYTE;
    case (phase)
      qfs_pkg::PH_QUOTED: begin
        if (is_nul || (is_quote && (delimiter == qfs_pkg::CH_QUOTE))) begin
          result.valid = 1'b1;
          result.kind  = qfs_pkg::KIND_END;
          result.last  = is_nul;
        end else if (!is_quote && !is_bslash) begin
          result.valid = 1'b1;
          result.data  = in_byte;
        end
      end
      qfs_pkg::PH_ESCAPE: begin
        result.valid = 1'b1;
        if (is_nul) begin
          result.kind = qfs_pkg::KIND_END;
          result.last = 1'b1;
        end else if (in_byte == qfs_pkg::CH_LOWER_T) begin
          result.data = qfs_pkg::CH_TAB;
        end else if (in_byte == qfs_pkg::CH_LOWER_N) begin
          result.data = qfs_pkg::CH_NEWLINE;
        end else begin
          result.data = in_byte;
        end
      end
      qfs_pkg::PH_CLOSED: begin
        if (is_sep) begin
          result.valid = 1'b1;
          result.kind  = qfs_pkg::KIND_END;
          result.last  = is_nul;
        end
      end
      qfs_pkg::PH_PLAIN: begin
        result.valid = 1'b1;
        if (is_quote) begin
          result.kind = qfs_pkg::KIND_DISCARD;
        end else if (is_sep) begin
          result.kind = qfs_pkg::KIND_END;
          result.last = is_nul;
        end else begin
          result.data = in_byte;
        end
      end
      default: begin
        if (is_quote) begin
          result.valid = 1'b0;
        end else if (is_sep) begin
          result.valid = 1'b1;
          result.kind  = qfs_pkg::KIND_END;
          result.last  = is_nul;
        end else if (!is_blank) begin
          result.valid = 1'b1;
          result.data  = in_byte;
        end
      end
    endcase
  end

endmodule
